// File: design/sgvg_pkg.sv
// Shared constants, types and arithmetic helpers for the sphere grid vertex generator.
package sgvg_pkg;

    localparam int FRAC_BITS = 16;
    localparam int ROW_W     = 13;
    localparam int COL_W     = 14;
    localparam int RAD_W     = 16;
    localparam int POS_W     = 25;
    localparam int TEX_W     = 17;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    localparam int DIV_FRAC = 33;
    localparam int DIV_BPS  = 3;
    localparam int DIV_STG  = DIV_FRAC / DIV_BPS;
    localparam int Q_W      = DIV_FRAC + 1;
    localparam int DREM_W   = COL_W;

    localparam int CORDIC_STEPS = 31;
    localparam int CORDIC_PER   = 4;
    localparam int CORDIC_STG   = (CORDIC_STEPS + CORDIC_PER - 1) / CORDIC_PER;
    localparam int CORDIC_FRAC  = 30;
    localparam int CV_W         = 34;
    localparam longint CORDIC_X0 = 652032874;

    localparam int TRIG_W   = FRAC_BITS + 2;
    localparam int PROD_W   = 2 * TRIG_W;
    localparam int RPROD_W  = TRIG_W + RAD_W + 1;
    localparam int POS_SH   = FRAC_BITS - 8;
    localparam longint POS_LIMIT = 16776960;

    localparam logic [ROW_W-1:0] STACK_RESET  = 13'd1024;
    localparam logic [COL_W-1:0] SLICE_RESET  = 14'd2048;
    localparam logic [RAD_W-1:0] RADIUS_RESET = 16'd6371;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STACK_COUNT   = 2'd0,
        REG_SLICE_COUNT   = 2'd1,
        REG_SPHERE_RADIUS = 2'd2
    } t_cfg_reg;

    localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
        32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1
    };

    typedef struct packed {
        logic [DREM_W-1:0] rem;
        logic [Q_W-1:0]    q;
    } t_div;

    typedef struct packed {
        logic signed [CV_W-1:0] x;
        logic signed [CV_W-1:0] y;
        logic signed [CV_W-1:0] z;
        logic                   flip;
    } t_rot;

    typedef struct packed {
        logic [TEX_W-1:0] u;
        logic [TEX_W-1:0] v;
    } t_tex;

    // Restoring division, DIV_BPS quotient bits; remainder stays below the divisor.
    function automatic t_div div_step(input t_div a, input logic [DREM_W-1:0] d);
        logic [DREM_W:0] w;
        t_div r;
        r = a;
        for (int k = 0; k < DIV_BPS; k++) begin
            w = {r.rem, 1'b0};
            if (w >= {1'b0, d}) begin
                w   = w - {1'b0, d};
                r.q = {r.q[Q_W-2:0], 1'b1};
            end else begin
                r.q = {r.q[Q_W-2:0], 1'b0};
            end
            r.rem = w[DREM_W-1:0];
        end
        return r;
    endfunction

    function automatic t_rot cordic_iter(input t_rot a, input int base);
        t_rot r;
        logic signed [CV_W-1:0] nx;
        logic signed [CV_W-1:0] at;
        int i;
        r = a;
        for (int k = 0; k < CORDIC_PER; k++) begin
            i = base + k;
            if (i < CORDIC_STEPS) begin
                at = $signed({2'b00, ATAN_TURNS[i]});
                if (r.z >= 0) begin
                    nx  = r.x - (r.y >>> i);
                    r.y = r.y + (r.x >>> i);
                    r.z = r.z - at;
                end else begin
                    nx  = r.x + (r.y >>> i);
                    r.y = r.y - (r.x >>> i);
                    r.z = r.z + at;
                end
                r.x = nx;
            end
        end
        return r;
    endfunction

    // Shift right, rounding half away from zero.
    function automatic logic signed [63:0] round_shift(input logic signed [63:0] v,
                                                       input int sh);
        logic [63:0] mag;
        if (sh == 0) begin
            return v;
        end
        mag = (v < 0) ? 64'(-v) : 64'(v);
        mag = (mag + (64'd1 << (sh - 1))) >> sh;
        return (v < 0) ? -$signed(mag) : $signed(mag);
    endfunction

    function automatic logic signed [63:0] clamp(input logic signed [63:0] v,
                                                 input longint lim);
        if (v > lim) begin
            return lim;
        end
        if (v < -lim) begin
            return -lim;
        end
        return v;
    endfunction

endpackage

// File: design/sgvg_in_if.sv
// Grid point request channel.
interface sgvg_in_if;
    logic                            valid;
    logic                            ready;
    logic [sgvg_pkg::ROW_W-1:0]      row_index;
    logic [sgvg_pkg::COL_W-1:0]      column_index;

    modport source(output valid, row_index, column_index, input ready);
    modport sink(input valid, row_index, column_index, output ready);
endinterface

// File: design/sgvg_out_if.sv
// Vertex result channel.
interface sgvg_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [sgvg_pkg::POS_W-1:0]  pos_x;
    logic signed [sgvg_pkg::POS_W-1:0]  pos_y;
    logic signed [sgvg_pkg::POS_W-1:0]  pos_z;
    logic [sgvg_pkg::TEX_W-1:0]         tex_u;
    logic [sgvg_pkg::TEX_W-1:0]         tex_v;

    modport source(output valid, pos_x, pos_y, pos_z, tex_u, tex_v, input ready);
    modport sink(input valid, pos_x, pos_y, pos_z, tex_u, tex_v, output ready);
endinterface

// File: design/sphere_grid_vertex_generator_unit.sv
// Pipeline: divider, CORDIC and scaling stages, in that order;
// the phase setup between divider and CORDIC is combinational. One vertex per cycle
// sustained, set by the fully pipelined divider and CORDIC. A stall at the output
// freezes every stage at once.
// Reset: synchronous, active low; clears the valid bits and loads stack count 1024,
// slice count 2048, radius 6371. No clearing pass is needed.
module sphere_grid_vertex_generator_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    sgvg_in_if.sink                          i_in,
    sgvg_out_if.source                       o_out,
    input  logic                             i_cfg_we,
    input  logic [sgvg_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [sgvg_pkg::CFG_W-1:0]       i_cfg_data
);
    logic [sgvg_pkg::ROW_W-1:0] r_stack_count;
    logic [sgvg_pkg::COL_W-1:0] r_slice_count;
    logic [sgvg_pkg::RAD_W-1:0] r_sphere_radius;

    logic en;
    logic [sgvg_pkg::DREM_W-1:0] stacks, slices;

    logic                     div_valid;
    logic [sgvg_pkg::Q_W-1:0] qr, qc;
    logic [31:0]              lat_ph, lon_ph;
    sgvg_pkg::t_tex           tex;

    logic           cor_valid;
    sgvg_pkg::t_rot cor_lat, cor_lon;
    sgvg_pkg::t_tex cor_tex;

    logic           post_valid;
    sgvg_pkg::t_tex post_tex;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stack_count   <= sgvg_pkg::STACK_RESET;
            r_slice_count   <= sgvg_pkg::SLICE_RESET;
            r_sphere_radius <= sgvg_pkg::RADIUS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sgvg_pkg::REG_STACK_COUNT:   r_stack_count   <= i_cfg_data[sgvg_pkg::ROW_W-1:0];
                sgvg_pkg::REG_SLICE_COUNT:   r_slice_count   <= i_cfg_data[sgvg_pkg::COL_W-1:0];
                sgvg_pkg::REG_SPHERE_RADIUS: r_sphere_radius <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Advance unless a finished result waits on a stalled sink.
    assign en = !(post_valid && !o_out.ready);
    assign i_in.ready = en;

    // A zero count acts as one.
    assign stacks = (r_stack_count == '0) ? sgvg_pkg::DREM_W'(1)
                                          : sgvg_pkg::DREM_W'(r_stack_count);
    assign slices = (r_slice_count == '0) ? sgvg_pkg::DREM_W'(1) : r_slice_count;

    sgvg_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (i_in.valid),
        .i_row    (i_in.row_index),
        .i_col    (i_in.column_index),
        .i_stacks (stacks),
        .i_slices (slices),
        .o_valid  (div_valid),
        .o_qr     (qr),
        .o_qc     (qc)
    );

    // Round the 2^33-scaled quotients down to phases and texture coordinates.
    always_comb begin
        lat_ph = 32'((((qr >> 1) + sgvg_pkg::Q_W'(1)) >> 1)) - 32'h4000_0000;
        lon_ph = 32'((qc + sgvg_pkg::Q_W'(1)) >> 1);
        tex.u  = sgvg_pkg::TEX_W'(((qc >> 16) + sgvg_pkg::Q_W'(1)) >> 1);
        tex.v  = sgvg_pkg::TEX_W'(17'd65536
                 - sgvg_pkg::TEX_W'(((qr >> 16) + sgvg_pkg::Q_W'(1)) >> 1));
    end

    sgvg_cordic u_cordic (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (div_valid),
        .i_lat_ph (lat_ph),
        .i_lon_ph (lon_ph),
        .i_tex    (tex),
        .o_valid  (cor_valid),
        .o_lat    (cor_lat),
        .o_lon    (cor_lon),
        .o_tex    (cor_tex)
    );

    sgvg_post u_post (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (cor_valid),
        .i_lat    (cor_lat),
        .i_lon    (cor_lon),
        .i_tex    (cor_tex),
        .i_radius (r_sphere_radius),
        .o_valid  (post_valid),
        .o_pos_x  (o_out.pos_x),
        .o_pos_y  (o_out.pos_y),
        .o_pos_z  (o_out.pos_z),
        .o_tex    (post_tex)
    );

    assign o_out.valid = post_valid;
    assign o_out.tex_u = post_tex.u;
    assign o_out.tex_v = post_tex.v;
endmodule

// File: design/sgvg_div.sv
// Pipelined two-lane divider: index scaled by 2^33 over the grid count.
module sgvg_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [sgvg_pkg::ROW_W-1:0]    i_row,
    input  logic [sgvg_pkg::COL_W-1:0]    i_col,
    input  logic [sgvg_pkg::DREM_W-1:0]   i_stacks,
    input  logic [sgvg_pkg::DREM_W-1:0]   i_slices,
    output logic                          o_valid,
    output logic [sgvg_pkg::Q_W-1:0]      o_qr,
    output logic [sgvg_pkg::Q_W-1:0]      o_qc
);
    logic [sgvg_pkg::DIV_STG:0] r_v;
    sgvg_pkg::t_div r_row [sgvg_pkg::DIV_STG+1];
    sgvg_pkg::t_div r_col [sgvg_pkg::DIV_STG+1];

    logic [sgvg_pkg::DREM_W-1:0] row_ext, row_sat, col_sat;
    sgvg_pkg::t_div row_init, col_init;

    // Saturate to the count; the integer quotient bit is then 0 or 1.
    always_comb begin
        row_ext = sgvg_pkg::DREM_W'(i_row);
        row_sat = (row_ext > i_stacks) ? i_stacks : row_ext;
        col_sat = (i_col > i_slices) ? i_slices : i_col;
        row_init.q   = sgvg_pkg::Q_W'(row_sat == i_stacks);
        row_init.rem = (row_sat == i_stacks) ? '0 : row_sat;
        col_init.q   = sgvg_pkg::Q_W'(col_sat == i_slices);
        col_init.rem = (col_sat == i_slices) ? '0 : col_sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[sgvg_pkg::DIV_STG-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_row[0] <= row_init;
            r_col[0] <= col_init;
            for (int s = 1; s <= sgvg_pkg::DIV_STG; s++) begin
                r_row[s] <= sgvg_pkg::div_step(r_row[s-1], i_stacks);
                r_col[s] <= sgvg_pkg::div_step(r_col[s-1], i_slices);
            end
        end
    end

    assign o_valid = r_v[sgvg_pkg::DIV_STG];
    assign o_qr    = r_row[sgvg_pkg::DIV_STG].q;
    assign o_qc    = r_col[sgvg_pkg::DIV_STG].q;
endmodule

// File: design/sgvg_cordic.sv
// Pipelined two-lane rotation CORDIC for latitude and longitude phases.
module sgvg_cordic (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [31:0]         i_lat_ph,
    input  logic [31:0]         i_lon_ph,
    input  sgvg_pkg::t_tex      i_tex,
    output logic                o_valid,
    output sgvg_pkg::t_rot      o_lat,
    output sgvg_pkg::t_rot      o_lon,
    output sgvg_pkg::t_tex      o_tex
);
    localparam int NS = sgvg_pkg::CORDIC_STG;

    logic [NS:0]    r_v;
    sgvg_pkg::t_rot r_lat [NS+1];
    sgvg_pkg::t_rot r_lon [NS+1];
    sgvg_pkg::t_tex r_tex [NS+1];

    sgvg_pkg::t_rot lat_pre, lon_pre;

    // Fold phases beyond a quarter turn by half a turn; negate at the end.
    function automatic sgvg_pkg::t_rot prerotate(input logic [31:0] ph);
        sgvg_pkg::t_rot r;
        r.x    = sgvg_pkg::CV_W'(sgvg_pkg::CORDIC_X0);
        r.y    = '0;
        r.z    = $signed({{(sgvg_pkg::CV_W-32){ph[31]}}, ph});
        r.flip = 1'b0;
        if (r.z > $signed(sgvg_pkg::CV_W'(64'sd1 << 30))) begin
            r.z    = r.z - $signed(sgvg_pkg::CV_W'(64'sd1 << 31));
            r.flip = 1'b1;
        end else if (r.z < -$signed(sgvg_pkg::CV_W'(64'sd1 << 30))) begin
            r.z    = r.z + $signed(sgvg_pkg::CV_W'(64'sd1 << 31));
            r.flip = 1'b1;
        end
        return r;
    endfunction

    always_comb begin
        lat_pre = prerotate(i_lat_ph);
        lon_pre = prerotate(i_lon_ph);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[NS-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lat[0] <= lat_pre;
            r_lon[0] <= lon_pre;
            r_tex[0] <= i_tex;
            for (int s = 1; s <= NS; s++) begin
                r_lat[s] <= sgvg_pkg::cordic_iter(r_lat[s-1], (s - 1) * sgvg_pkg::CORDIC_PER);
                r_lon[s] <= sgvg_pkg::cordic_iter(r_lon[s-1], (s - 1) * sgvg_pkg::CORDIC_PER);
                r_tex[s] <= r_tex[s-1];
            end
        end
    end

    assign o_valid = r_v[NS];
    assign o_lat   = r_lat[NS];
    assign o_lon   = r_lon[NS];
    assign o_tex   = r_tex[NS];
endmodule

// File: design/sgvg_post.sv
// Rounds the CORDIC outputs and scales them by the radius into positions.
module sgvg_post (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  sgvg_pkg::t_rot                    i_lat,
    input  sgvg_pkg::t_rot                    i_lon,
    input  sgvg_pkg::t_tex                    i_tex,
    input  logic [sgvg_pkg::RAD_W-1:0]        i_radius,
    output logic                              o_valid,
    output logic signed [sgvg_pkg::POS_W-1:0] o_pos_x,
    output logic signed [sgvg_pkg::POS_W-1:0] o_pos_y,
    output logic signed [sgvg_pkg::POS_W-1:0] o_pos_z,
    output sgvg_pkg::t_tex                    o_tex
);
    localparam int TW = sgvg_pkg::TRIG_W;
    localparam int RSH = sgvg_pkg::CORDIC_FRAC - sgvg_pkg::FRAC_BITS;
    localparam longint ONE = 64'sd1 <<< sgvg_pkg::FRAC_BITS;

    logic [3:0] r_v;

    logic signed [TW-1:0] r_cl, r_sl, r_co, r_so;
    sgvg_pkg::t_tex r_tex1, r_tex2, r_tex3, r_tex4;

    logic signed [sgvg_pkg::PROD_W-1:0]  r_mx, r_my;
    logic signed [sgvg_pkg::RPROD_W-1:0] r_mz;

    logic signed [sgvg_pkg::RPROD_W-1:0] r_px, r_py;
    logic signed [sgvg_pkg::POS_W-1:0]   r_pz3;

    logic signed [sgvg_pkg::POS_W-1:0]   r_pos_x, r_pos_y, r_pos_z;

    logic signed [sgvg_pkg::RAD_W:0] rad;
    logic signed [TW-1:0]            cx, cy;

    function automatic logic signed [TW-1:0] trig(input logic signed [sgvg_pkg::CV_W-1:0] v,
                                                   input logic flip);
        logic signed [sgvg_pkg::CV_W-1:0] f;
        f = flip ? -v : v;
        return TW'(sgvg_pkg::clamp(sgvg_pkg::round_shift(f, RSH), ONE));
    endfunction

    function automatic logic signed [sgvg_pkg::POS_W-1:0] to_pos(
        input logic signed [63:0] v);
        return sgvg_pkg::POS_W'(sgvg_pkg::clamp(sgvg_pkg::round_shift(v, sgvg_pkg::POS_SH),
                                                sgvg_pkg::POS_LIMIT));
    endfunction

    always_comb begin
        rad = $signed({1'b0, i_radius});
        cx  = TW'(sgvg_pkg::round_shift(r_mx, sgvg_pkg::FRAC_BITS));
        cy  = TW'(sgvg_pkg::round_shift(r_my, sgvg_pkg::FRAC_BITS));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cl   <= trig(i_lat.x, i_lat.flip);
            r_sl   <= trig(i_lat.y, i_lat.flip);
            r_co   <= trig(i_lon.x, i_lon.flip);
            r_so   <= trig(i_lon.y, i_lon.flip);
            r_tex1 <= i_tex;

            r_mx   <= r_cl * r_co;
            r_my   <= r_cl * r_so;
            r_mz   <= r_sl * rad;
            r_tex2 <= r_tex1;

            r_px   <= cx * rad;
            r_py   <= cy * rad;
            r_pz3  <= to_pos(r_mz);
            r_tex3 <= r_tex2;

            r_pos_x <= to_pos(r_px);
            r_pos_y <= to_pos(r_py);
            r_pos_z <= r_pz3;
            r_tex4  <= r_tex3;
        end
    end

    assign o_valid = r_v[3];
    assign o_pos_x = r_pos_x;
    assign o_pos_y = r_pos_y;
    assign o_pos_z = r_pos_z;
    assign o_tex   = r_tex4;
endmodule

// File: tb/sv/sphere_grid_vertex_generator_unit_test.sv
`timescale 1ns / 1ps
// Self-checking testbench: directed and random grid points, checked against a CORDIC predictor.
module sphere_grid_vertex_generator_unit_test;
    import sgvg_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 200;

    typedef struct {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
        logic [TEX_W-1:0]        u;
        logic [TEX_W-1:0]        v;
    } t_vertex;

    class vertex_tracker;
        t_vertex pending_vertices[$];
        logic [ROW_W-1:0] stacks;
        logic [COL_W-1:0] slices;
        logic [RAD_W-1:0] radius;
        int errors;

        function void reset_regs();
            stacks = STACK_RESET;
            slices = SLICE_RESET;
            radius = RADIUS_RESET;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                REG_STACK_COUNT: stacks = data[ROW_W-1:0];
                REG_SLICE_COUNT: slices = data[COL_W-1:0];
                REG_SPHERE_RADIUS: radius = data[RAD_W-1:0];
                default: ;
            endcase
        endfunction

        // Round half away from zero.
        function longint rnd_shift(longint v, int sh);
            longint unsigned mag;
            if (sh == 0) return v;
            mag = (v < 0) ? -v : v;
            mag = (mag + (64'd1 << (sh - 1))) >> sh;
            return (v < 0) ? -longint'(mag) : longint'(mag);
        endfunction

        function longint lim(longint v, longint l);
            if (v > l) return l;
            if (v < -l) return -l;
            return v;
        endfunction

        function void sin_cos(logic [31:0] phase, output longint c, output longint s);
            longint z, x, y, nx, at;
            bit flip;
            z = phase;
            x = CORDIC_X0;
            y = 0;
            flip = 0;
            if (z >= (64'sd1 << 31)) z -= (64'sd1 << 32);
            if (z > (64'sd1 << 30)) begin
                z -= (64'sd1 << 31);
                flip = 1;
            end else if (z < -(64'sd1 << 30)) begin
                z += (64'sd1 << 31);
                flip = 1;
            end
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                at = ATAN_TURNS[i];
                if (z >= 0) begin
                    nx = x - (y >>> i);
                    y  = y + (x >>> i);
                    z  = z - at;
                end else begin
                    nx = x + (y >>> i);
                    y  = y - (x >>> i);
                    z  = z + at;
                end
                x = nx;
            end
            if (flip) begin
                x = -x;
                y = -y;
            end
            c = lim(rnd_shift(x, CORDIC_FRAC - FRAC_BITS), 64'sd1 << FRAC_BITS);
            s = lim(rnd_shift(y, CORDIC_FRAC - FRAC_BITS), 64'sd1 << FRAC_BITS);
        endfunction

        function t_vertex predict_vertex(logic [ROW_W-1:0] row_in, logic [COL_W-1:0] col_in);
            longint unsigned st, sl, row, col, tv;
            logic [31:0] lat_ph, lon_ph;
            longint cl, sla, co, so, r;
            t_vertex vx;
            st = (stacks == 0) ? 1 : stacks;
            sl = (slices == 0) ? 1 : slices;
            row = (row_in > st) ? st : row_in;
            col = (col_in > sl) ? sl : col_in;
            lat_ph = 32'(((row << 31) + st / 2) / st - (64'd1 << 30));
            lon_ph = 32'(((col << 32) + sl / 2) / sl);
            sin_cos(lat_ph, cl, sla);
            sin_cos(lon_ph, co, so);
            r = radius;
            vx.x = POS_W'(lim(rnd_shift(rnd_shift(cl * co, FRAC_BITS) * r, FRAC_BITS - 8),
                              POS_LIMIT));
            vx.y = POS_W'(lim(rnd_shift(rnd_shift(cl * so, FRAC_BITS) * r, FRAC_BITS - 8),
                              POS_LIMIT));
            vx.z = POS_W'(lim(rnd_shift(sla * r, FRAC_BITS - 8), POS_LIMIT));
            vx.u = TEX_W'(((col << 16) + sl / 2) / sl);
            tv = 65536 - ((row << 16) + st / 2) / st;
            vx.v = TEX_W'(tv);
            return vx;
        endfunction

        function void note_grid_point(logic [ROW_W-1:0] row, logic [COL_W-1:0] col);
            pending_vertices.insert(pending_vertices.size(), predict_vertex(row, col));
        endfunction

        function void check_vertex(t_vertex got);
            t_vertex want;
            if (pending_vertices.size() == 0) begin
                $display("%0t: unexpected vertex x=%0d y=%0d z=%0d u=%0d v=%0d",
                         $time, got.x, got.y, got.z, got.u, got.v);
                errors++;
                return;
            end
            want = pending_vertices.pop_front();
            if (got.x !== want.x) begin
                $display("%0t: pos_x expected %0d actual %0d", $time, want.x, got.x);
                errors++;
            end
            if (got.y !== want.y) begin
                $display("%0t: pos_y expected %0d actual %0d", $time, want.y, got.y);
                errors++;
            end
            if (got.z !== want.z) begin
                $display("%0t: pos_z expected %0d actual %0d", $time, want.z, got.z);
                errors++;
            end
            if (got.u !== want.u) begin
                $display("%0t: tex_u expected %0d actual %0d", $time, want.u, got.u);
                errors++;
            end
            if (got.v !== want.v) begin
                $display("%0t: tex_v expected %0d actual %0d", $time, want.v, got.v);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_cfg_we = 0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0] i_cfg_data = '0;

    sgvg_in_if  grid_ch();
    sgvg_out_if vert_ch();

    sphere_grid_vertex_generator_unit dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in(grid_ch.sink),
        .o_out(vert_ch.source),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    vertex_tracker tracker = new();
    int send_idle_pct = 28;
    int recv_idle_pct = 62;
    bit hold_req = 0;

    always #5 i_clk = ~i_clk;

    initial begin
        #10ms;
        $display("FAIL");
        $finish;
    end

    // Receiver: random backpressure, with one long hold-off on request.
    initial begin
        vert_ch.ready = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                vert_ch.ready = 0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 0;
            end else begin
                vert_ch.ready = ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_vertex got;
        if (i_rst_n && vert_ch.valid && vert_ch.ready) begin
            got.x = vert_ch.pos_x;
            got.y = vert_ch.pos_y;
            got.z = vert_ch.pos_z;
            got.u = vert_ch.tex_u;
            got.v = vert_ch.tex_v;
            tracker.check_vertex(got);
        end
    end

    task automatic send_point(logic [ROW_W-1:0] row, logic [COL_W-1:0] col);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            grid_ch.valid = 0;
            @(negedge i_clk);
        end
        grid_ch.valid = 1;
        grid_ch.row_index = row;
        grid_ch.column_index = col;
        do @(posedge i_clk); while (!grid_ch.ready);
        tracker.note_grid_point(row, col);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(negedge i_clk);
        grid_ch.valid = 0;
        i_cfg_we = 1;
        i_cfg_idx = idx;
        i_cfg_data = data;
        tracker.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we = 0;
    endtask

    task automatic drain();
        @(negedge i_clk);
        grid_ch.valid = 0;
        while (tracker.pending_vertices.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_counts(logic [CFG_W-1:0] st, logic [CFG_W-1:0] sl,
                              logic [CFG_W-1:0] rad);
        write_reg(REG_STACK_COUNT, st);
        write_reg(REG_SLICE_COUNT, sl);
        write_reg(REG_SPHERE_RADIUS, rad);
    endtask

    task automatic random_points(int n, bit with_hold);
        int st, sl;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        for (int k = 0; k < n; k++) begin
            if (with_hold && k == 10) hold_req = 1;
            st = (tracker.stacks == 0) ? 1 : tracker.stacks;
            sl = (tracker.slices == 0) ? 1 : tracker.slices;
            // mostly in range, sometimes across the whole field to hit saturation
            row = ($urandom_range(9) < 8) ? ROW_W'($urandom_range(st, 0))
                                          : ROW_W'($urandom_range(8191, 0));
            col = ($urandom_range(9) < 8) ? COL_W'($urandom_range(sl, 0))
                                          : COL_W'($urandom_range(16383, 0));
            send_point(row, col);
        end
    endtask

    initial begin
        grid_ch.valid = 0;
        grid_ch.row_index = '0;
        grid_ch.column_index = '0;
        tracker.reset_regs();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // reset settings: poles, equator, seam and saturation
        send_point(0, 0);
        send_point(1024, 2048);
        send_point(512, 512);
        send_point(512, 1024);
        send_point(512, 1536);
        send_point(256, 256);
        send_point(768, 1792);
        send_point(8191, 16383);
        send_point(1025, 2049);
        send_point(13'h1555, 14'h2AAA);
        send_point(13'h0AAA, 14'h1555);
        send_point(1, 1);
        send_point(1023, 2047);
        random_points(60, 0);
        drain();

        for (int ph = 1; ph < 7; ph++) begin
            if (ph < 3) begin
                send_idle_pct = 28;
                recv_idle_pct = 62;
            end else if (ph < 5) begin
                send_idle_pct = 62;
                recv_idle_pct = 28;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (ph)
                1: set_counts(1, 1, 1);
                2: set_counts(4096, 8192, 65535);
                3: set_counts(0, 0, 65535);
                4: begin
                    set_counts(16'hFFFF, 16'hFFFF, 16'hAAAA);
                    write_reg(REG_UNUSED, 16'h5555);
                end
                5: set_counts(CFG_W'($urandom_range(64, 1)), CFG_W'($urandom_range(64, 1)),
                              CFG_W'($urandom_range(65535, 1)));
                default: set_counts(7, 12, 16'h5555);
            endcase
            send_point(0, 0);
            send_point(8191, 16383);
            random_points(70, ph == 2);
            drain();
        end

        if (tracker.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
